// ----- src/pbpb_pkg.sv -----
// Shared types and constants of the packet byte pattern blocker.
package pbpb_pkg;

  localparam int REG_PAT_BYTES = 16;
  localparam int LEN_W = 5;
  localparam int COUNT_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

  typedef logic [7:0] byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LEN_W-1:0] len_t;

endpackage

// ----- src/pbpb_in_if.sv -----
// Channel that carries packet bytes into the blocker.
interface pbpb_in_if
  import pbpb_pkg::*;
  ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  end_of_packet;

  modport source (output valid, output data_byte, output end_of_packet, input ready);
  modport sink (input valid, input data_byte, input end_of_packet, output ready);
  modport monitor (input valid, input data_byte, input end_of_packet, input ready);
endinterface

// ----- src/pbpb_out_if.sv -----
// Channel that carries per-packet verdicts out of the blocker.
interface pbpb_out_if
  import pbpb_pkg::*;
  ();
  logic   valid;
  logic   ready;
  logic   drop_packet;
  count_t packet_length;

  modport source (output valid, output drop_packet, output packet_length, input ready);
  modport sink (input valid, input drop_packet, input packet_length, output ready);
  modport monitor (input valid, input drop_packet, input packet_length, input ready);
endinterface

// ----- src/pbpb_cfg_if.sv -----
// Register write channel of the blocker.
interface pbpb_cfg_if
  import pbpb_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
  modport monitor (input valid, input index, input data, input ready);
endinterface

// ----- src/packet_byte_pattern_blocker.sv -----
// A verdict is presented in the cycle after the packet's final byte is accepted.
// One byte per cycle while pkt.ready is high; all pattern bytes are compared in parallel.
// A byte is taken whenever the verdict register is empty or being read in the same cycle.
// Reset (synchronous, active high) clears the registers, the byte count, the match flag
// and the verdict valid; register writes are always taken.
module packet_byte_pattern_blocker
  import pbpb_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 16
) (
  input  logic      clk,
  input  logic      rst,
  pbpb_in_if.sink   pkt,
  pbpb_out_if.source result,
  pbpb_cfg_if.sink  cfg
);

  localparam int WINDOW_DEPTH =
    (MAX_PATTERN_BYTES < REG_PAT_BYTES) ? MAX_PATTERN_BYTES : REG_PAT_BYTES;
  localparam len_t WINDOW_LEN = len_t'(WINDOW_DEPTH);

  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  len_t                  pattern_length;

  byte_t  recent_bytes [WINDOW_DEPTH];
  byte_t  window_next  [WINDOW_DEPTH];
  byte_t  pat_byte_vec [REG_PAT_BYTES];
  count_t bytes_seen;
  count_t bytes_seen_next;
  logic   match_seen;
  logic   match_now;
  logic   accept;
  len_t   eff_len;
  logic [WINDOW_DEPTH-1:0] byte_ok;

  assign cfg.ready = 1'b1;
  assign pkt.ready = !result.valid || result.ready;
  assign accept = pkt.valid && pkt.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low <= '0;
      pattern_high <= '0;
      pattern_length <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PATTERN_LOW:    pattern_low <= cfg.data;
        REG_PATTERN_HIGH:   pattern_high <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < REG_PAT_BYTES / 2; k++) begin
      pat_byte_vec[k] = pattern_low[8*k +: 8];
      pat_byte_vec[k + REG_PAT_BYTES / 2] = pattern_high[8*k +: 8];
    end
  end

  // Lengths beyond the register file or the window clamp to the window depth.
  assign eff_len = (pattern_length > WINDOW_LEN) ? WINDOW_LEN : pattern_length;

  always_comb begin
    window_next[0] = pkt.data_byte;
    for (int j = 1; j < WINDOW_DEPTH; j++) begin
      window_next[j] = recent_bytes[j-1];
    end
  end

  assign bytes_seen_next = (bytes_seen == COUNT_LIMIT) ? bytes_seen : bytes_seen + 1'b1;

  // Window entry j holds the byte that came j items ago and must equal
  // pattern byte eff_len-1-j whenever j lies inside the pattern.
  always_comb begin
    for (int j = 0; j < WINDOW_DEPTH; j++) begin
      byte_ok[j] = (len_t'(j) >= eff_len) ||
                   (window_next[j] ==
                    pat_byte_vec[4'(eff_len - len_t'(j) - len_t'(1))]);
    end
  end

  assign match_now = (bytes_seen_next >= count_t'(eff_len)) && (&byte_ok);

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < WINDOW_DEPTH; j++) begin
        recent_bytes[j] <= window_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      match_seen <= 1'b0;
    end else if (accept) begin
      if (pkt.end_of_packet) begin
        bytes_seen <= '0;
        match_seen <= 1'b0;
      end else begin
        bytes_seen <= bytes_seen_next;
        match_seen <= match_seen || match_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && pkt.end_of_packet) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pkt.end_of_packet) begin
      result.drop_packet <= match_seen || match_now;
      result.packet_length <= bytes_seen_next;
    end
  end

endmodule

// ----- src/pbpb_checker.sv -----
// Port-level checks of the blocker and the bind that attaches them.
module pbpb_checker
  import pbpb_pkg::*;
  (
  input logic   clk,
  input logic   rst,
  input logic   pkt_valid,
  input logic   pkt_ready,
  input logic   pkt_eop,
  input logic   res_valid,
  input logic   res_ready,
  input logic   res_drop,
  input count_t res_length
);

  logic last_taken;
  assign last_taken = pkt_valid && pkt_ready && pkt_eop;

  // A final byte always produces a verdict in the next cycle.
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    last_taken |=> res_valid)
    else $error("no verdict after the final byte of a packet");

  // A verdict that was taken is not repeated unless a new packet ended.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready && !last_taken) |=> !res_valid)
    else $error("verdict shown again without a new packet");

  // Every verdict covers at least one byte.
  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_length != '0))
    else $error("verdict with zero packet length");

  // A stalled verdict holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(res_drop) && $stable(res_length)))
    else $error("stalled verdict changed");

endmodule

bind packet_byte_pattern_blocker pbpb_checker u_pbpb_checker (
  .clk        (clk),
  .rst        (rst),
  .pkt_valid  (pkt.valid),
  .pkt_ready  (pkt.ready),
  .pkt_eop    (pkt.end_of_packet),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_drop   (result.drop_packet),
  .res_length (result.packet_length)
);
